[hw/rtl/srecord_s1_writer_assert.svh]
// Assertion macros for the S1 record writer.
// Used by srecord_s1_writer.sv; the asserting module supplies clk and rst.
`ifndef SRECORD_S1_WRITER_ASSERT_SVH
`define SRECORD_S1_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

`define SRW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SRW_ASSERT_IMPLIES(lbl, ante, cons, msg)

`define SRW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/srw_pkg.sv]
// Shared constants and character helpers for the S1 record writer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package srw_pkg;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADDR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_END  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_S  = 8'h53;
  localparam logic [CHAR_W-1:0] CHAR_1  = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  // Terminator record "S9030000FC", sent without line end
  localparam logic [3:0] S9_LAST = 4'd9;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] c;
    if (v <= 4'd9) begin
      c = 8'h30 + {4'h0, v};
    end else begin
      c = 8'h37 + {4'h0, v};
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] s9_char(input logic [3:0] i);
    logic [CHAR_W-1:0] c;
    case (i)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h39;
      4'd3:    c = 8'h33;
      4'd8:    c = 8'h46;
      4'd9:    c = 8'h43;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/srw_if.sv]
// Valid/ready channel interfaces of the S1 record writer.
// Depends on srw_pkg for payload widths.
`timescale 1ns / 1ps

interface srw_item_if import srw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [7:0]        data_byte;
  logic [ADDR_W-1:0] new_address;

  modport source (output valid, func, data_byte, new_address, input ready);
  modport sink   (input valid, func, data_byte, new_address, output ready);
endinterface

interface srw_char_if import srw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

[hw/rtl/srecord_s1_writer.sv]
// S1 record writer: accepting a data item that does not fill a record leaves the input
// ready. A flush loads its first character into the output register once that register
// is free after the accepting edge; n bytes leave as 2n+12 characters, one per cycle
// while the output is not stalled, and the S9 terminator adds 10. The input is ready
// again the cycle after the last character loads.
// Reset clears the counter, byte count, sum and sequencer, not the byte store.
`timescale 1ns / 1ps

`include "srecord_s1_writer_assert.svh"

module srecord_s1_writer import srw_pkg::*; #(
  parameter int RECORD_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  srw_item_if.sink      items,
  srw_char_if.source    chars
);

  localparam int HELD_W  = $clog2(RECORD_BYTES + 1);
  localparam int SLOT_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int IDX_RAW = $clog2(RECORD_BYTES + 4);
  localparam int IDX_W   = (IDX_RAW > 4) ? IDX_RAW : 4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HDR  = 6'b000010,
    S_HEX  = 6'b000100,
    S_CR   = 6'b001000,
    S_LF   = 6'b010000,
    S_TERM = 6'b100000
  } state_t;

  state_t              state;
  logic [7:0]          byte_store [RECORD_BYTES];
  logic [HELD_W-1:0]   held;
  logic [ADDR_W-1:0]   rec_addr;
  logic [ADDR_W-1:0]   counter;
  logic [7:0]          sum;

  logic [HELD_W-1:0]   rec_len;
  logic [7:0]          chk;
  logic                term_after;
  logic [IDX_W-1:0]    idx;
  logic                nib;
  logic [7:0]          cur_byte;

  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;

  logic                acc, is_data, data_flush, cmd_flush, flush_go, end_now;
  logic [HELD_W-1:0]   held_inc, flush_len;
  logic [ADDR_W-1:0]   flush_addr;
  logic [7:0]          sum_inc, flush_sum, flush_cnt, flush_chk;

  logic                out_free, gen_fire, gen_last, hex_done, byte_adv, from_mem;
  logic [CHAR_W-1:0]   gen_char;
  logic [IDX_W-1:0]    rec_end, idx_nxt, rd_pos;
  logic [SLOT_W-1:0]   rd_addr;
  logic [7:0]          byte_val;

  assign items.ready     = (state == S_IDLE);
  assign chars.valid     = out_valid;
  assign chars.out_char  = out_char;
  assign chars.last_char = out_last;

  // Input side: byte buffering and flush setup
  assign acc        = items.valid && items.ready;
  assign is_data    = (items.func == FUNC_DATA);
  assign held_inc   = held + HELD_W'(1);
  assign sum_inc    = sum + items.data_byte;
  assign data_flush = acc && is_data && (held_inc == HELD_W'(RECORD_BYTES));
  assign cmd_flush  = acc && ((items.func == FUNC_ADDR) || (items.func == FUNC_END))
                      && (held != '0);
  assign flush_go   = data_flush || cmd_flush;
  assign end_now    = acc && (items.func == FUNC_END) && (held == '0);

  assign flush_len  = is_data ? held_inc : held;
  assign flush_addr = (is_data && (held == '0)) ? counter : rec_addr;
  assign flush_sum  = is_data ? sum_inc : sum;
  assign flush_cnt  = 8'(flush_len) + 8'd3;
  assign flush_chk  = ~(flush_cnt + flush_addr[15:8] + flush_addr[7:0] + flush_sum);

  // Character sequencer
  assign out_free = !out_valid || chars.ready;
  assign gen_fire = (state != S_IDLE) && out_free;
  assign rec_end  = IDX_W'(rec_len) + IDX_W'(3);
  assign idx_nxt  = idx + IDX_W'(1);
  assign hex_done = nib && (idx == rec_end);
  assign byte_adv = gen_fire && (state == S_HEX) && nib && !hex_done;
  assign rd_pos   = idx - IDX_W'(2);
  assign rd_addr  = rd_pos[SLOT_W-1:0];
  assign from_mem = (idx_nxt >= IDX_W'(3)) && (idx_nxt < rec_end);

  always_comb begin
    if (idx_nxt == IDX_W'(1)) begin
      byte_val = rec_addr[15:8];
    end else if (idx_nxt == IDX_W'(2)) begin
      byte_val = rec_addr[7:0];
    end else begin
      byte_val = chk;
    end
  end

  always_comb begin
    gen_char = CHAR_S;
    gen_last = 1'b0;
    case (state)
      S_HDR:  gen_char = nib ? CHAR_1 : CHAR_S;
      S_HEX:  gen_char = hex_char(nib ? cur_byte[3:0] : cur_byte[7:4]);
      S_CR:   gen_char = CHAR_CR;
      S_LF: begin
        gen_char = CHAR_LF;
        gen_last = !term_after;
      end
      S_TERM: begin
        gen_char = s9_char(idx[3:0]);
        gen_last = (idx[3:0] == S9_LAST);
      end
      default: gen_char = CHAR_S;
    endcase
  end

  // Byte store and payload registers
  always_ff @(posedge clk) begin
    if (acc && is_data) begin
      byte_store[held[SLOT_W-1:0]] <= items.data_byte;
    end
    if (flush_go) begin
      cur_byte   <= flush_cnt;
      chk        <= flush_chk;
      rec_len    <= flush_len;
      term_after <= (items.func == FUNC_END);
    end else if (byte_adv) begin
      if (from_mem) begin
        cur_byte <= byte_store[rd_addr];
      end else begin
        cur_byte <= byte_val;
      end
    end
    if (gen_fire) begin
      out_char <= gen_char;
      out_last <= gen_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      rec_addr  <= '0;
      counter   <= '0;
      sum       <= '0;
      idx       <= '0;
      nib       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        case (items.func)
          FUNC_DATA: begin
            if (held == '0) begin
              rec_addr <= counter;
            end
            counter <= counter + ADDR_W'(1);
            if (data_flush) begin
              held <= '0;
              sum  <= '0;
            end else begin
              held <= held_inc;
              sum  <= sum_inc;
            end
          end
          FUNC_ADDR: begin
            counter <= items.new_address;
            held    <= '0;
            sum     <= '0;
          end
          FUNC_END: begin
            held <= '0;
            sum  <= '0;
          end
          default: ;
        endcase
      end

      if (flush_go) begin
        state <= S_HDR;
        idx   <= '0;
        nib   <= 1'b0;
      end else if (end_now) begin
        state <= S_TERM;
        idx   <= '0;
      end else if (gen_fire) begin
        case (state)
          S_HDR: begin
            nib <= !nib;
            if (nib) begin
              state <= S_HEX;
            end
          end
          S_HEX: begin
            if (!nib) begin
              nib <= 1'b1;
            end else if (hex_done) begin
              state <= S_CR;
            end else begin
              nib <= 1'b0;
              idx <= idx_nxt;
            end
          end
          S_CR: state <= S_LF;
          S_LF: begin
            if (term_after) begin
              state <= S_TERM;
              idx   <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
          S_TERM: begin
            if (idx[3:0] == S9_LAST) begin
              state <= S_IDLE;
            end else begin
              idx <= idx_nxt;
            end
          end
          default: state <= S_IDLE;
        endcase
      end

      if (gen_fire) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SRW_ASSERT_IMPLIES(a_held_bound, state == S_IDLE, held < HELD_W'(RECORD_BYTES), "byte count reached record size while idle")
  `SRW_ASSERT_IMPLIES(a_busy_clear, state != S_IDLE, held == '0 && sum == '0, "buffer not cleared during record output")
  `SRW_ASSERT_IMPLIES(a_hex_range, state == S_HEX, idx <= rec_end, "hex byte index ran past checksum")
  `SRW_ASSERT_NEXT(a_last_idle, gen_fire && gen_last, state == S_IDLE, "sequencer busy after last character")

endmodule
